// ===== src/power_trace_session_buffer_assert.svh =====
// Assertion macros for the power trace session buffer.
// Depends on nothing; taken in by ptsb_ctrl, which checks its own logic.
`ifndef POWER_TRACE_SESSION_BUFFER_ASSERT_SVH
`define POWER_TRACE_SESSION_BUFFER_ASSERT_SVH

// a at one edge implies b at the same edge
`define PTSB_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ptsb check failed");

// a at one edge implies b at the next edge
`define PTSB_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ptsb check failed");

`endif

// ===== src/ptsb_pkg.sv =====
// Shared types and constants of the power trace session buffer.
// Depends on nothing; used by the controller, the datapath and the top level.
package ptsb_pkg;

    localparam int SAMPLE_AW     = 12;
    localparam int SAMPLE_DEPTH  = 1 << SAMPLE_AW;
    localparam int SESSION_AW    = 6;
    localparam int SESSION_DEPTH = 1 << SESSION_AW;

    localparam logic [2:0] OPC_CLEAR = 3'd0;
    localparam logic [2:0] OPC_BEGIN = 3'd1;
    localparam logic [2:0] OPC_END   = 3'd2;
    localparam logic [2:0] OPC_ADD   = 3'd3;
    localparam logic [2:0] OPC_INFO  = 3'd4;
    localparam logic [2:0] OPC_QUERY = 3'd5;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [4:0] UOP_NOP            = 5'd0;
    localparam logic [4:0] UOP_LATCH          = 5'd1;
    localparam logic [4:0] UOP_CLEAR          = 5'd2;
    localparam logic [4:0] UOP_RD_NEWEST      = 5'd3;
    localparam logic [4:0] UOP_END_CHK        = 5'd4;
    localparam logic [4:0] UOP_SLOT_TAIL      = 5'd5;
    localparam logic [4:0] UOP_SLOT_BACK      = 5'd6;
    localparam logic [4:0] UOP_RD_SLOT_START  = 5'd7;
    localparam logic [4:0] UOP_RD_SLOT_NEXT   = 5'd8;
    localparam logic [4:0] UOP_LEN            = 5'd9;
    localparam logic [4:0] UOP_DROP           = 5'd10;
    localparam logic [4:0] UOP_BEGIN_WR       = 5'd11;
    localparam logic [4:0] UOP_CHUNK          = 5'd12;
    localparam logic [4:0] UOP_NEED1          = 5'd13;
    localparam logic [4:0] UOP_TRIM_RD        = 5'd14;
    localparam logic [4:0] UOP_TRIM_RD2       = 5'd15;
    localparam logic [4:0] UOP_TRIM_WR        = 5'd16;
    localparam logic [4:0] UOP_SKIP_DEC       = 5'd17;
    localparam logic [4:0] UOP_ADD_RD         = 5'd18;
    localparam logic [4:0] UOP_ADD_WR         = 5'd19;
    localparam logic [4:0] UOP_INFO_OUT       = 5'd20;
    localparam logic [4:0] UOP_SCAN_INIT      = 5'd21;
    localparam logic [4:0] UOP_SCAN           = 5'd22;
    localparam logic [4:0] UOP_FIN_RD         = 5'd23;
    localparam logic [4:0] UOP_FIN            = 5'd24;
    localparam logic [4:0] UOP_STATUS1        = 5'd25;
    localparam logic [4:0] UOP_STATUS2        = 5'd26;

    typedef struct packed {
        logic [4:0] uop;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       first;
        logic       sess_empty;
        logic       sess_multi;
        logic       wrap_full;
        logic       room_lt_need;
        logic       fits;
        logic       back_oor;
        logic       skip_nz;
        logic       samples_full;
        logic       scan_done;
    } stat_t;

endpackage

// ===== src/power_trace_session_buffer.sv =====
// Top level of the power trace session buffer: controller plus datapath.
// Depends on ptsb_pkg, ptsb_ctrl and ptsb_datapath.
//
//   channel   handshake          payload
//   command   start / busy       operation .. session_back
//   result    done (one cycle)   status .. sample_count
//
// One word at a time; busy falls as the done strobe rises.
// An address query holds busy while it reads the sample store, one stored sample at a time.
// Room making looks at the oldest sessions, drops those that fit, then trims oldest samples.
// rst_n clears pointers and chunk skip; the receiver cannot stall results.
module power_trace_session_buffer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [31:0] start_seconds,
    input  logic [31:0] sample_current,
    input  logic [19:0] address,
    input  logic        chunk_first,
    input  logic [15:0] chunk_count,
    input  logic [5:0]  session_back,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] session_time,
    output logic [11:0] session_samples,
    output logic [63:0] session_total,
    output logic [11:0] match_count,
    output logic [63:0] match_sum,
    output logic [19:0] last_address,
    output logic [5:0]  session_count,
    output logic [11:0] sample_count
);

    ptsb_pkg::cmd_t  cmd;
    ptsb_pkg::stat_t stat;

    ptsb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ptsb_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .operation       (operation),
        .start_seconds   (start_seconds),
        .sample_current  (sample_current),
        .address         (address),
        .chunk_first     (chunk_first),
        .chunk_count     (chunk_count),
        .session_back    (session_back),
        .done            (done),
        .status          (status),
        .session_time    (session_time),
        .session_samples (session_samples),
        .session_total   (session_total),
        .match_count     (match_count),
        .match_sum       (match_sum),
        .last_address    (last_address),
        .session_count   (session_count),
        .sample_count    (sample_count)
    );

endmodule

// ===== src/ptsb_ctrl.sv =====
// Controller state machine of the power trace session buffer.
// Depends on ptsb_pkg and power_trace_session_buffer_assert.svh.
`include "power_trace_session_buffer_assert.svh"

module ptsb_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ptsb_pkg::stat_t stat,
    output ptsb_pkg::cmd_t  cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_END_CHK = 5'd2;
    localparam logic [4:0] S_B_FULL  = 5'd3;
    localparam logic [4:0] S_B_WR    = 5'd4;
    localparam logic [4:0] S_L_RD0   = 5'd5;
    localparam logic [4:0] S_L_RD1   = 5'd6;
    localparam logic [4:0] S_L_LEN   = 5'd7;
    localparam logic [4:0] S_L_USE   = 5'd8;
    localparam logic [4:0] S_MR1     = 5'd9;
    localparam logic [4:0] S_MR2     = 5'd10;
    localparam logic [4:0] S_T_RD2   = 5'd11;
    localparam logic [4:0] S_T_WR    = 5'd12;
    localparam logic [4:0] S_ADD_SKP = 5'd13;
    localparam logic [4:0] S_ADD_RD  = 5'd14;
    localparam logic [4:0] S_ADD_WR  = 5'd15;
    localparam logic [4:0] S_SCAN    = 5'd16;
    localparam logic [4:0] S_FIN_RD  = 5'd17;
    localparam logic [4:0] S_FIN     = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       phase_reg;
    logic       phase_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd.uop    = ptsb_pkg::UOP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.uop    = ptsb_pkg::UOP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.op) inside
                    ptsb_pkg::OPC_CLEAR:
                    begin
                        cmd.uop    = ptsb_pkg::UOP_CLEAR;
                        state_next = S_FIN_RD;
                    end
                    ptsb_pkg::OPC_BEGIN, ptsb_pkg::OPC_END:
                    begin
                        if (stat.sess_empty)
                            state_next = (stat.op == ptsb_pkg::OPC_BEGIN) ? S_B_FULL : S_FIN_RD;
                        else
                        begin
                            cmd.uop    = ptsb_pkg::UOP_RD_NEWEST;
                            state_next = S_END_CHK;
                        end
                    end
                    ptsb_pkg::OPC_ADD:
                    begin
                        if (stat.sess_empty)
                        begin
                            cmd.uop    = ptsb_pkg::UOP_STATUS1;
                            state_next = S_FIN_RD;
                        end
                        else if (stat.first)
                        begin
                            cmd.uop    = ptsb_pkg::UOP_CHUNK;
                            phase_next = 1'b0;
                            state_next = S_MR1;
                        end
                        else
                            state_next = S_ADD_SKP;
                    end
                    ptsb_pkg::OPC_INFO:
                    begin
                        if (stat.back_oor)
                        begin
                            cmd.uop    = ptsb_pkg::UOP_STATUS2;
                            state_next = S_FIN_RD;
                        end
                        else
                        begin
                            cmd.uop    = ptsb_pkg::UOP_SLOT_BACK;
                            state_next = S_L_RD0;
                        end
                    end
                    ptsb_pkg::OPC_QUERY:
                    begin
                        cmd.uop    = ptsb_pkg::UOP_SCAN_INIT;
                        state_next = S_SCAN;
                    end
                    default:
                        state_next = S_FIN_RD;
                endcase
            end
            S_END_CHK:
            begin
                cmd.uop    = ptsb_pkg::UOP_END_CHK;
                state_next = (stat.op == ptsb_pkg::OPC_BEGIN) ? S_B_FULL : S_FIN_RD;
            end
            S_B_FULL:
            begin
                if (stat.wrap_full)
                begin
                    cmd.uop    = ptsb_pkg::UOP_SLOT_TAIL;
                    state_next = S_L_RD0;
                end
                else
                    state_next = S_B_WR;
            end
            S_B_WR:
            begin
                cmd.uop    = ptsb_pkg::UOP_BEGIN_WR;
                state_next = S_FIN_RD;
            end
            S_L_RD0:
            begin
                cmd.uop    = ptsb_pkg::UOP_RD_SLOT_START;
                state_next = S_L_RD1;
            end
            S_L_RD1:
            begin
                cmd.uop    = ptsb_pkg::UOP_RD_SLOT_NEXT;
                state_next = S_L_LEN;
            end
            S_L_LEN:
            begin
                cmd.uop    = ptsb_pkg::UOP_LEN;
                state_next = S_L_USE;
            end
            S_L_USE:
            begin
                if (stat.op == ptsb_pkg::OPC_BEGIN)
                begin
                    cmd.uop    = ptsb_pkg::UOP_DROP;
                    state_next = S_B_WR;
                end
                else if (stat.op == ptsb_pkg::OPC_INFO)
                begin
                    cmd.uop    = ptsb_pkg::UOP_INFO_OUT;
                    state_next = S_FIN_RD;
                end
                else if (stat.fits)
                begin
                    cmd.uop    = ptsb_pkg::UOP_DROP;
                    state_next = S_MR1;
                end
                else
                    state_next = S_MR2;
            end
            S_MR1:
            begin
                if (stat.room_lt_need && stat.sess_multi)
                begin
                    cmd.uop    = ptsb_pkg::UOP_SLOT_TAIL;
                    state_next = S_L_RD0;
                end
                else
                    state_next = S_MR2;
            end
            S_MR2:
            begin
                if (stat.room_lt_need && !stat.sess_empty)
                begin
                    cmd.uop    = ptsb_pkg::UOP_TRIM_RD;
                    state_next = S_T_RD2;
                end
                else
                    state_next = phase_reg ? S_ADD_RD : S_ADD_SKP;
            end
            S_T_RD2:
            begin
                cmd.uop    = ptsb_pkg::UOP_TRIM_RD2;
                state_next = S_T_WR;
            end
            S_T_WR:
            begin
                cmd.uop    = ptsb_pkg::UOP_TRIM_WR;
                state_next = S_MR2;
            end
            S_ADD_SKP:
            begin
                if (stat.skip_nz)
                begin
                    cmd.uop    = ptsb_pkg::UOP_SKIP_DEC;
                    state_next = S_FIN_RD;
                end
                else if (stat.samples_full)
                begin
                    cmd.uop    = ptsb_pkg::UOP_NEED1;
                    phase_next = 1'b1;
                    state_next = S_MR1;
                end
                else
                    state_next = S_ADD_RD;
            end
            S_ADD_RD:
            begin
                cmd.uop    = ptsb_pkg::UOP_ADD_RD;
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cmd.uop    = ptsb_pkg::UOP_ADD_WR;
                state_next = S_FIN_RD;
            end
            S_SCAN:
            begin
                cmd.uop = ptsb_pkg::UOP_SCAN;
                if (stat.scan_done)
                    state_next = S_FIN_RD;
            end
            S_FIN_RD:
            begin
                cmd.uop    = ptsb_pkg::UOP_FIN_RD;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.uop    = ptsb_pkg::UOP_FIN;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    `PTSB_ASSERT_NEXT(a_accept_disp, clk, rst_n, start && !busy, state_reg == S_DISP)
    `PTSB_ASSERT_NOW(a_trim_order, clk, rst_n, state_reg == S_T_WR, $past(state_reg) == S_T_RD2)
    `PTSB_ASSERT_NEXT(a_fin_idle, clk, rst_n, state_reg == S_FIN, state_reg == S_IDLE)

endmodule

// ===== src/ptsb_datapath.sv =====
// Datapath of the power trace session buffer: ring pointers, sample and
// session stores, scan accumulator and result registers. Depends on ptsb_pkg.
module ptsb_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptsb_pkg::cmd_t         cmd,
    output ptsb_pkg::stat_t        stat,
    input  logic [2:0]             operation,
    input  logic [31:0]            start_seconds,
    input  logic [31:0]            sample_current,
    input  logic [19:0]            address,
    input  logic                   chunk_first,
    input  logic [15:0]            chunk_count,
    input  logic [5:0]             session_back,
    output logic                   done,
    output logic [1:0]             status,
    output logic [31:0]            session_time,
    output logic [11:0]            session_samples,
    output logic [63:0]            session_total,
    output logic [11:0]            match_count,
    output logic [63:0]            match_sum,
    output logic [19:0]            last_address,
    output logic [5:0]             session_count,
    output logic [11:0]            sample_count
);

    localparam int PW = ptsb_pkg::SAMPLE_AW;
    localparam int NW = ptsb_pkg::SESSION_AW;
    localparam logic [PW-1:0] KEEP_MAX = PW'(ptsb_pkg::SAMPLE_DEPTH - 1);

    logic [31:0]   cur_mem   [ptsb_pkg::SAMPLE_DEPTH];
    logic [19:0]   addr_mem  [ptsb_pkg::SAMPLE_DEPTH];
    logic [PW-1:0] start_mem [ptsb_pkg::SESSION_DEPTH];
    logic [31:0]   time_mem  [ptsb_pkg::SESSION_DEPTH];
    logic [63:0]   total_mem [ptsb_pkg::SESSION_DEPTH];

    logic [2:0]    op_reg;
    logic [31:0]   clock_in_reg;
    logic [31:0]   cur_in_reg;
    logic [19:0]   addr_in_reg;
    logic          first_reg;
    logic [15:0]   count_reg;
    logic [NW-1:0] back_reg;

    logic [NW-1:0] s_head_reg;
    logic [NW-1:0] s_tail_reg;
    logic [PW-1:0] p_head_reg;
    logic [PW-1:0] p_tail_reg;
    logic [15:0]   skip_reg;
    logic          scan_vld_reg;
    logic          done_reg;

    logic [NW-1:0] slot_reg;
    logic [PW-1:0] need_reg;
    logic [PW-1:0] len_reg;
    logic [PW-1:0] start_a_reg;
    logic [31:0]   time_a_reg;
    logic [63:0]   total_a_reg;
    logic [PW-1:0] scan_ptr_reg;
    logic [PW-1:0] scan_left_reg;
    logic [11:0]   hits_reg;
    logic [63:0]   sum_reg;
    logic [19:0]   last_addr_reg;

    logic [PW-1:0] rd_start_reg;
    logic [31:0]   rd_time_reg;
    logic [63:0]   rd_total_reg;
    logic [31:0]   rd_cur_reg;
    logic [19:0]   rd_addr_reg;

    logic [1:0]    res_status_reg;
    logic [31:0]   res_time_reg;
    logic [11:0]   res_len_reg;
    logic [63:0]   res_total_reg;
    logic [11:0]   res_count_reg;
    logic [63:0]   res_sum_reg;
    logic [19:0]   res_last_reg;
    logic [5:0]    res_nsess_reg;
    logic [11:0]   res_nsamp_reg;

    logic [NW-1:0] newest;
    logic [NW-1:0] nsess;
    logic [PW-1:0] nsamp;
    logic [PW-1:0] room;
    logic [PW-1:0] len_end;
    logic [NW-1:0] s_raddr;
    logic [NW-1:0] s_waddr;
    logic [PW-1:0] p_raddr;
    logic          we_start;
    logic          we_time;
    logic          we_total;
    logic [PW-1:0] wd_start;
    logic [63:0]   wd_total;
    logic          count_big;

    assign newest    = s_head_reg - NW'(1);
    assign nsess     = s_head_reg - s_tail_reg;
    assign nsamp     = p_head_reg - p_tail_reg;
    assign room      = p_tail_reg - p_head_reg - PW'(1);
    assign len_end   = ((slot_reg + NW'(1)) == s_head_reg) ? p_head_reg : rd_start_reg;
    assign count_big = (count_reg > 16'(KEEP_MAX));

    assign stat.op           = op_reg;
    assign stat.first        = first_reg;
    assign stat.sess_empty   = (s_head_reg == s_tail_reg);
    assign stat.sess_multi   = (nsess > NW'(1));
    assign stat.wrap_full    = ((s_head_reg + NW'(1)) == s_tail_reg);
    assign stat.room_lt_need = (room < need_reg);
    assign stat.fits         = (({1'b0, room} + {1'b0, len_reg}) <= {1'b0, need_reg});
    assign stat.back_oor     = (back_reg >= nsess);
    assign stat.skip_nz      = (skip_reg != 16'd0);
    assign stat.samples_full = (nsamp == KEEP_MAX);
    assign stat.scan_done    = (scan_left_reg == PW'(0)) && !scan_vld_reg;

    always_comb
    begin
        s_raddr  = newest;
        s_waddr  = newest;
        p_raddr  = scan_ptr_reg;
        we_start = 1'b0;
        we_time  = 1'b0;
        we_total = 1'b0;
        wd_start = p_head_reg;
        wd_total = 64'd0;
        unique case (cmd.uop)
            ptsb_pkg::UOP_RD_SLOT_START: s_raddr = slot_reg;
            ptsb_pkg::UOP_RD_SLOT_NEXT:  s_raddr = slot_reg + NW'(1);
            ptsb_pkg::UOP_TRIM_RD:       s_raddr = s_tail_reg;
            ptsb_pkg::UOP_TRIM_RD2:      p_raddr = rd_start_reg;
            ptsb_pkg::UOP_BEGIN_WR:
            begin
                s_waddr  = s_head_reg;
                we_start = 1'b1;
                we_time  = 1'b1;
                we_total = 1'b1;
            end
            ptsb_pkg::UOP_TRIM_WR:
            begin
                s_waddr  = s_tail_reg;
                we_start = 1'b1;
                we_total = 1'b1;
                wd_start = start_a_reg + PW'(1);
                wd_total = total_a_reg - {32'd0, rd_cur_reg};
            end
            ptsb_pkg::UOP_ADD_WR:
            begin
                we_total = 1'b1;
                wd_total = rd_total_reg + {32'd0, cur_in_reg};
            end
            default:
            begin
                s_raddr = newest;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_start)
            start_mem[s_waddr] <= wd_start;
        if (we_time)
            time_mem[s_waddr] <= clock_in_reg;
        if (we_total)
            total_mem[s_waddr] <= wd_total;
        rd_start_reg <= start_mem[s_raddr];
        rd_time_reg  <= time_mem[s_raddr];
        rd_total_reg <= total_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.uop == ptsb_pkg::UOP_ADD_WR)
        begin
            cur_mem[p_head_reg]  <= cur_in_reg;
            addr_mem[p_head_reg] <= addr_in_reg;
        end
        rd_cur_reg  <= cur_mem[p_raddr];
        rd_addr_reg <= addr_mem[p_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_head_reg   <= '0;
            s_tail_reg   <= '0;
            p_head_reg   <= '0;
            p_tail_reg   <= '0;
            skip_reg     <= '0;
            scan_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.uop == ptsb_pkg::UOP_FIN);
            case (cmd.uop)
                ptsb_pkg::UOP_CLEAR:
                begin
                    s_head_reg <= '0;
                    s_tail_reg <= '0;
                    p_head_reg <= '0;
                    p_tail_reg <= '0;
                    skip_reg   <= '0;
                end
                ptsb_pkg::UOP_END_CHK:
                begin
                    if (rd_start_reg == p_head_reg)
                        s_head_reg <= newest;
                end
                ptsb_pkg::UOP_DROP:
                begin
                    p_tail_reg <= p_tail_reg + len_reg;
                    s_tail_reg <= s_tail_reg + NW'(1);
                end
                ptsb_pkg::UOP_BEGIN_WR:
                    s_head_reg <= s_head_reg + NW'(1);
                ptsb_pkg::UOP_CHUNK:
                    skip_reg <= count_big ? (count_reg - 16'(KEEP_MAX)) : 16'd0;
                ptsb_pkg::UOP_TRIM_WR:
                    p_tail_reg <= p_tail_reg + PW'(1);
                ptsb_pkg::UOP_SKIP_DEC:
                    skip_reg <= skip_reg - 16'd1;
                ptsb_pkg::UOP_ADD_WR:
                    p_head_reg <= p_head_reg + PW'(1);
                ptsb_pkg::UOP_SCAN_INIT:
                    scan_vld_reg <= 1'b0;
                ptsb_pkg::UOP_SCAN:
                    scan_vld_reg <= (scan_left_reg != PW'(0));
                default:
                    scan_vld_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.uop)
            ptsb_pkg::UOP_LATCH:
            begin
                op_reg         <= operation;
                clock_in_reg   <= start_seconds;
                cur_in_reg     <= sample_current;
                addr_in_reg    <= address;
                first_reg      <= chunk_first;
                count_reg      <= chunk_count;
                back_reg       <= session_back;
                res_status_reg <= ptsb_pkg::ST_DONE;
                res_time_reg   <= '0;
                res_len_reg    <= '0;
                res_total_reg  <= '0;
                hits_reg       <= '0;
                sum_reg        <= '0;
            end
            ptsb_pkg::UOP_STATUS1:
                res_status_reg <= ptsb_pkg::ST_IGNORED;
            ptsb_pkg::UOP_STATUS2:
                res_status_reg <= ptsb_pkg::ST_RANGE;
            ptsb_pkg::UOP_SLOT_TAIL:
                slot_reg <= s_tail_reg;
            ptsb_pkg::UOP_SLOT_BACK:
                slot_reg <= newest - back_reg;
            ptsb_pkg::UOP_RD_SLOT_NEXT:
            begin
                start_a_reg <= rd_start_reg;
                time_a_reg  <= rd_time_reg;
                total_a_reg <= rd_total_reg;
            end
            ptsb_pkg::UOP_LEN:
                len_reg <= len_end - start_a_reg;
            ptsb_pkg::UOP_CHUNK:
                need_reg <= count_big ? KEEP_MAX : count_reg[PW-1:0];
            ptsb_pkg::UOP_NEED1:
                need_reg <= PW'(1);
            ptsb_pkg::UOP_TRIM_RD2:
            begin
                start_a_reg <= rd_start_reg;
                total_a_reg <= rd_total_reg;
            end
            ptsb_pkg::UOP_ADD_WR:
                last_addr_reg <= addr_in_reg;
            ptsb_pkg::UOP_INFO_OUT:
            begin
                res_time_reg  <= time_a_reg;
                res_len_reg   <= 12'(len_reg);
                res_total_reg <= total_a_reg;
            end
            ptsb_pkg::UOP_SCAN_INIT:
            begin
                scan_ptr_reg  <= p_tail_reg;
                scan_left_reg <= nsamp;
            end
            ptsb_pkg::UOP_SCAN:
            begin
                if (scan_left_reg != PW'(0))
                begin
                    scan_ptr_reg  <= scan_ptr_reg + PW'(1);
                    scan_left_reg <= scan_left_reg - PW'(1);
                end
                if (scan_vld_reg && (rd_addr_reg == addr_in_reg))
                begin
                    hits_reg <= hits_reg + 12'd1;
                    sum_reg  <= sum_reg + {32'd0, rd_cur_reg};
                end
            end
            ptsb_pkg::UOP_FIN:
            begin
                res_count_reg <= hits_reg;
                res_sum_reg   <= sum_reg;
                res_nsess_reg <= 6'(nsess);
                res_nsamp_reg <= 12'(nsamp);
                if ((s_head_reg != s_tail_reg) && (rd_start_reg != p_head_reg))
                    res_last_reg <= last_addr_reg;
                else
                    res_last_reg <= '0;
            end
            default:
            begin
                slot_reg <= slot_reg;
            end
        endcase
    end

    assign done            = done_reg;
    assign status          = res_status_reg;
    assign session_time    = res_time_reg;
    assign session_samples = res_len_reg;
    assign session_total   = res_total_reg;
    assign match_count     = res_count_reg;
    assign match_sum       = res_sum_reg;
    assign last_address    = res_last_reg;
    assign session_count   = res_nsess_reg;
    assign sample_count    = res_nsamp_reg;

endmodule

// ===== tb/tb_power_trace_session_buffer.sv =====
// Self-checking testbench for power_trace_session_buffer: directed words, then random
// session traffic, checked against an in-bench prediction of the session and sample rings.
// Depends on ptsb_pkg and the power_trace_session_buffer RTL.
`timescale 1ns / 100ps

module tb_power_trace_session_buffer;

    localparam logic [2:0] OPC_SPARE6 = 3'd6;
    localparam logic [2:0] OPC_SPARE7 = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 100000000;
    localparam int unsigned RANDOM_WORDS = 1900;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] wclk;
        logic [31:0] cur;
        logic [19:0] addr;
        logic        first;
        logic [15:0] count;
        logic [5:0]  back;
    } word_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] stime;
        logic [11:0] slen;
        logic [63:0] stotal;
        logic [11:0] mcount;
        logic [63:0] msum;
        logic [19:0] laddr;
        logic [5:0]  scount;
        logic [11:0] pcount;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  operation;
    logic [31:0] start_seconds;
    logic [31:0] sample_current;
    logic [19:0] address;
    logic        chunk_first;
    logic [15:0] chunk_count;
    logic [5:0]  session_back;
    logic        done;
    logic [1:0]  status;
    logic [31:0] session_time;
    logic [11:0] session_samples;
    logic [63:0] session_total;
    logic [11:0] match_count;
    logic [63:0] match_sum;
    logic [19:0] last_address;
    logic [5:0]  session_count;
    logic [11:0] sample_count;

    power_trace_session_buffer dut (.*);

    // predicted buffer contents
    logic [31:0] pr_cur   [ptsb_pkg::SAMPLE_DEPTH];
    logic [19:0] pr_addr  [ptsb_pkg::SAMPLE_DEPTH];
    int unsigned pr_start [ptsb_pkg::SESSION_DEPTH];
    logic [31:0] pr_time  [ptsb_pkg::SESSION_DEPTH];
    logic [63:0] pr_total [ptsb_pkg::SESSION_DEPTH];
    int unsigned smp_head, smp_tail, ses_head, ses_tail, skip_left;

    word_t       pending_words[$];
    reply_t      expected_replies[$];
    int unsigned errors, words_sent, replies_seen, cycles;
    int unsigned op_seen[8];
    bit          quiet_stretch;

    function automatic int unsigned sessions_held();
        return (ses_head + ptsb_pkg::SESSION_DEPTH - ses_tail) % ptsb_pkg::SESSION_DEPTH;
    endfunction

    function automatic int unsigned samples_held();
        return (smp_head + ptsb_pkg::SAMPLE_DEPTH - smp_tail) % ptsb_pkg::SAMPLE_DEPTH;
    endfunction

    function automatic int unsigned slot_by_age(int unsigned age);
        return (ses_head + ptsb_pkg::SESSION_DEPTH - 1 - (age % ptsb_pkg::SESSION_DEPTH))
               % ptsb_pkg::SESSION_DEPTH;
    endfunction

    function automatic int unsigned slot_len(int unsigned slot);
        int unsigned nxt;
        int unsigned stop;
        nxt = (slot + 1) % ptsb_pkg::SESSION_DEPTH;
        stop = (nxt != ses_head) ? pr_start[nxt] : smp_head;
        return (stop + ptsb_pkg::SAMPLE_DEPTH - pr_start[slot]) % ptsb_pkg::SAMPLE_DEPTH;
    endfunction

    task automatic drop_oldest();
        smp_tail = (smp_tail + slot_len(ses_tail)) % ptsb_pkg::SAMPLE_DEPTH;
        ses_tail = (ses_tail + 1) % ptsb_pkg::SESSION_DEPTH;
    endtask

    task automatic free_room(int unsigned need);
        int unsigned room;
        int unsigned len;
        int unsigned s;
        room = (smp_tail + ptsb_pkg::SAMPLE_DEPTH - smp_head - 1) % ptsb_pkg::SAMPLE_DEPTH;
        while (room < need && sessions_held() > 1) begin
            len = slot_len(ses_tail);
            if (room + len > need)
                break;
            drop_oldest();
            room += len;
        end
        while (room < need && sessions_held() > 0) begin
            s = pr_start[ses_tail] % ptsb_pkg::SAMPLE_DEPTH;
            pr_total[ses_tail] = pr_total[ses_tail] - 64'(pr_cur[s]);
            pr_start[ses_tail] = (s + 1) % ptsb_pkg::SAMPLE_DEPTH;
            smp_tail = (smp_tail + 1) % ptsb_pkg::SAMPLE_DEPTH;
            room++;
        end
    endtask

    task automatic close_session();
        int unsigned last;
        if (ses_head != ses_tail)
        begin
            last = slot_by_age(0);
            if (pr_start[last] == smp_head)
                ses_head = last;
        end
    endtask

    task automatic predict_reply(input word_t w, output reply_t r);
        int unsigned nh, slot, keep, p, hits;
        logic [63:0] sum;
        r = '{default: '0};
        case (w.op)
            ptsb_pkg::OPC_CLEAR:
            begin
                ses_head = 0; ses_tail = 0; smp_head = 0; smp_tail = 0; skip_left = 0;
            end
            ptsb_pkg::OPC_BEGIN:
            begin
                close_session();
                nh = (ses_head + 1) % ptsb_pkg::SESSION_DEPTH;
                if (nh == ses_tail)
                    drop_oldest();
                pr_time[ses_head] = w.wclk;
                pr_start[ses_head] = smp_head;
                pr_total[ses_head] = '0;
                ses_head = nh;
            end
            ptsb_pkg::OPC_END:
                close_session();
            ptsb_pkg::OPC_ADD:
            begin
                if (ses_head == ses_tail)
                    r.status = ptsb_pkg::ST_IGNORED;
                else
                begin
                    if (w.first)
                    begin
                        keep = 32'(w.count);
                        skip_left = 0;
                        if (keep > ptsb_pkg::SAMPLE_DEPTH - 1)
                        begin
                            skip_left = keep - (ptsb_pkg::SAMPLE_DEPTH - 1);
                            keep = ptsb_pkg::SAMPLE_DEPTH - 1;
                        end
                        free_room(keep);
                    end
                    if (skip_left > 0)
                        skip_left--;
                    else
                    begin
                        slot = slot_by_age(0);
                        if (samples_held() >= ptsb_pkg::SAMPLE_DEPTH - 1)
                            free_room(1);
                        pr_total[slot] = pr_total[slot] + 64'(w.cur);
                        pr_cur[smp_head] = w.cur;
                        pr_addr[smp_head] = w.addr;
                        smp_head = (smp_head + 1) % ptsb_pkg::SAMPLE_DEPTH;
                    end
                end
            end
            ptsb_pkg::OPC_INFO:
            begin
                if (32'(w.back) >= sessions_held())
                    r.status = ptsb_pkg::ST_RANGE;
                else
                begin
                    slot = slot_by_age(32'(w.back));
                    r.stime = pr_time[slot];
                    r.slen = 12'(slot_len(slot));
                    r.stotal = pr_total[slot];
                end
            end
            ptsb_pkg::OPC_QUERY:
            begin
                hits = 0;
                sum = '0;
                for (int unsigned i = 0; i < samples_held(); i++)
                begin
                    p = (smp_tail + i) % ptsb_pkg::SAMPLE_DEPTH;
                    if (pr_addr[p] == w.addr)
                    begin
                        hits++;
                        sum = sum + 64'(pr_cur[p]);
                    end
                end
                r.mcount = 12'(hits);
                r.msum = sum;
            end
            default: ;
        endcase
        if (ses_head != ses_tail && pr_start[slot_by_age(0)] != smp_head)
            r.laddr = pr_addr[(smp_head + ptsb_pkg::SAMPLE_DEPTH - 1) % ptsb_pkg::SAMPLE_DEPTH];
        r.scount = 6'(sessions_held());
        r.pcount = 12'(samples_held());
    endtask

    function automatic word_t random_word(logic [2:0] op);
        word_t w;
        w.op = op;
        w.wclk = $urandom;
        w.cur = $urandom;
        w.addr = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 7));
        w.first = 1'b0;
        w.count = 16'($urandom);
        w.back = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 6));
        return w;
    endfunction

    task automatic queue_word(word_t w);
        pending_words.push_back(w);
    endtask

    task automatic queue_chunk(int unsigned n, logic [15:0] announced);
        word_t w;
        for (int unsigned i = 0; i < n; i++)
        begin
            w = random_word(ptsb_pkg::OPC_ADD);
            w.first = (i == 0);
            w.count = announced;
            queue_word(w);
        end
    endtask

    function automatic bit report(string what, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver: advance to the next word once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        reply_t r;
        word_t  w;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                w = '{operation, start_seconds, sample_current, address, chunk_first,
                      chunk_count, session_back};
                predict_reply(w, r);
                expected_replies.push_back(r);
                op_seen[operation]++;
                words_sent++;
            end
            if (start && busy)
                ;
            else if (pending_words.size() > 0 &&
                     (quiet_stretch || $urandom_range(0, 99) >= 19))
            begin
                w = pending_words.pop_front();
                start <= 1'b1;
                operation <= w.op;
                start_seconds <= w.wclk;
                sample_current <= w.cur;
                address <= w.addr;
                chunk_first <= w.first;
                chunk_count <= w.count;
                session_back <= w.back;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check each result word against the oldest prediction
    always @(posedge clk)
    begin
        reply_t e;
        bit     bad;
        if (rst_n && done)
        begin
            replies_seen++;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
            end
            else
            begin
                e = expected_replies.pop_front();
                bad = report("status", 64'(e.status), 64'(status));
                bad |= report("session_time", 64'(e.stime), 64'(session_time));
                bad |= report("session_samples", 64'(e.slen), 64'(session_samples));
                bad |= report("session_total", e.stotal, session_total);
                bad |= report("match_count", 64'(e.mcount), 64'(match_count));
                bad |= report("match_sum", e.msum, match_sum);
                bad |= report("last_address", 64'(e.laddr), 64'(last_address));
                bad |= report("session_count", 64'(e.scount), 64'(session_count));
                bad |= report("sample_count", 64'(e.pcount), 64'(sample_count));
                if (bad)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        quiet_stretch <= (words_sent >= 700 && words_sent < 1000);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        word_t w;
        int unsigned kind, n;
        rst_n = 1'b0;
        start = 1'b0;
        operation = '0; start_seconds = '0; sample_current = '0; address = '0;
        chunk_first = 1'b0; chunk_count = '0; session_back = '0;
        errors = 0; words_sent = 0; replies_seen = 0; cycles = 0;
        quiet_stretch = 1'b0;
        foreach (op_seen[i]) op_seen[i] = 0;
        smp_head = 0; smp_tail = 0; ses_head = 0; ses_tail = 0; skip_left = 0;

        queue_word(random_word(ptsb_pkg::OPC_CLEAR));
        queue_chunk(1, 16'd1);
        w = random_word(ptsb_pkg::OPC_INFO); w.back = 6'd0; queue_word(w);
        w = random_word(ptsb_pkg::OPC_BEGIN); w.wclk = '0; queue_word(w);
        w = random_word(ptsb_pkg::OPC_BEGIN); w.wclk = '1; queue_word(w);
        w = random_word(ptsb_pkg::OPC_ADD); w.first = 1'b1; w.count = 16'd3;
        w.cur = '1; w.addr = '1; queue_word(w);
        w.first = 1'b0; w.cur = '1; queue_word(w);
        w.cur = '0; w.addr = '0; queue_word(w);
        w = random_word(ptsb_pkg::OPC_INFO); w.back = 6'd0; queue_word(w);
        w.back = 6'd63; queue_word(w);
        w = random_word(ptsb_pkg::OPC_QUERY); w.addr = '1; queue_word(w);
        w.addr = '0; queue_word(w);
        queue_word(random_word(ptsb_pkg::OPC_END));
        queue_word(random_word(ptsb_pkg::OPC_END));
        queue_word(random_word(ptsb_pkg::OPC_BEGIN));
        queue_chunk(3, 16'hFFFF);
        queue_word(random_word(OPC_SPARE6));
        queue_word(random_word(OPC_SPARE7));
        w = random_word(ptsb_pkg::OPC_INFO); w.back = 6'd1; queue_word(w);
        queue_word(random_word(ptsb_pkg::OPC_QUERY));
        queue_word(random_word(ptsb_pkg::OPC_CLEAR));

        while (pending_words.size() < RANDOM_WORDS + 22)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                queue_word(random_word(ptsb_pkg::OPC_BEGIN));
                n = $urandom_range(1, 12);
                case ($urandom_range(0, 19))
                    0: queue_chunk(n, 16'($urandom_range(1, 20)));
                    1: queue_chunk(n, 16'($urandom));
                    default: queue_chunk(n, 16'(n));
                endcase
                if ($urandom_range(0, 3) == 0)
                    queue_chunk(n, 16'(n));
                if ($urandom_range(0, 1) == 0)
                    queue_word(random_word(ptsb_pkg::OPC_END));
            end
            else if (kind < 55)
                queue_word(random_word(ptsb_pkg::OPC_INFO));
            else if (kind < 70)
                queue_word(random_word(ptsb_pkg::OPC_QUERY));
            else if (kind < 78)
                queue_word(random_word(ptsb_pkg::OPC_END));
            else if (kind < 80)
                queue_word(random_word(ptsb_pkg::OPC_CLEAR));
            else if (kind < 84)
                queue_word(random_word($urandom_range(0, 1) ? OPC_SPARE6 : OPC_SPARE7));
            else
            begin
                w = random_word(ptsb_pkg::OPC_ADD);
                w.first = 1'($urandom);
                w.count = 16'($urandom_range(1, 16));
                queue_word(w);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || start || expected_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d words (clear %0d, begin %0d, end %0d, add %0d, info %0d, query %0d)",
                 words_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
                 op_seen[5]);
        $display("checked %0d result words, %0d with errors", replies_seen, errors);
        if (errors == 0 && expected_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== power_trace_session_buffer.f =====
+incdir+src
src/ptsb_pkg.sv
src/ptsb_ctrl.sv
src/ptsb_datapath.sv
src/power_trace_session_buffer.sv
tb/tb_power_trace_session_buffer.sv
